### rtl/pllrw_pkg.sv
// ----------------------------------------------------------------------------
// pllrw_pkg: constants, types and helpers for the PLL register word builder
// Holds the frequency limits, base words, sequencer state type and the
// modulus rebuild function.
// ----------------------------------------------------------------------------
package pllrw_pkg;

	localparam int FREQ_W  = 24;   // input frequency field
	localparam int WORD_W  = 32;   // register word
	localparam int FCLP_W  = 23;   // clamped frequency
	localparam int DIVX_W  = 29;   // dividend of the /1000 unit
	localparam int QUO_W   = 20;   // quotient of the /1000 unit
	localparam int REM_W   = 10;   // remainder of the /1000 unit
	localparam int MHZ_W   = 13;
	localparam int CODE_W  = 3;
	localparam int PROD_W  = 53;
	localparam int RCP_W   = 24;
	localparam int RCP_SH  = 33;
	localparam int EXP_W   = 2;
	localparam int IDX_W   = 2;

	localparam logic [FCLP_W-1:0] FREQ_MIN_KHZ = 23'd35000;
	localparam logic [FCLP_W-1:0] FREQ_MAX_KHZ = 23'd4400000;
	localparam logic [18:0]       VCO_MIN_MHZ  = 19'd2200;
	localparam logic [18:0]       VCO_MAX_MHZ  = 19'd4400;
	localparam logic [CODE_W-1:0] DIV_CODE_MAX = 3'd6;
	// floor(2^33 / 1000)
	localparam logic [RCP_W-1:0]  RCP_1000     = 24'd8589934;
	localparam logic [10:0]       DIV_BASE     = 11'd1000;
	localparam logic [7:0]        RCP_5        = 8'd205;

	localparam logic [WORD_W-1:0] WORD_RF_OFF  = 32'h00EC801C;
	localparam logic [WORD_W-1:0] WORD_R1_BASE = 32'h00008001;
	localparam logic [WORD_W-1:0] WORD_R4_BASE = 32'h008C803C;

	localparam logic [IDX_W-1:0]  IDX_RF_OFF = 2'd0;
	localparam logic [IDX_W-1:0]  IDX_R1     = 2'd1;
	localparam logic [IDX_W-1:0]  IDX_R0     = 2'd2;
	localparam logic [IDX_W-1:0]  IDX_R4     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_SEARCH,
		ST_RED5,
		ST_RED2,
		ST_EMIT
	} state_t;

	// modulus = 2^e2 * 5^e5
	function automatic logic [REM_W-1:0] mod_value(input logic [EXP_W-1:0] e2,
			input logic [EXP_W-1:0] e5);
		logic [REM_W-1:0] p5;
		begin
			unique case (e5)
				2'd0: p5 = 10'd1;
				2'd1: p5 = 10'd5;
				2'd2: p5 = 10'd25;
				default: p5 = 10'd125;
			endcase
			mod_value = p5 << e2;
		end
	endfunction

endpackage

### rtl/pll_frequency_to_register_words_top.sv
// ----------------------------------------------------------------------------
// pll_frequency_to_register_words_top: frequency to synthesizer words
// Clamps a kHz request, finds the output divider, splits the VCO value into
// INT/FRAC, reduces FRAC/MOD and emits RF-off, R1, R0, R4 in order.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                          handshake
//  s_axis    in   tdata[23:0] = freq_khz           tvalid/tready
//  m_axis    out  tdata[31:0] = reg_word,          tvalid/tready
//                 tlast = is_last (on R4)
//
//  Per request a shared /1000 unit (reciprocal multiply, then correction)
//  runs twice, the divider search steps one code per cycle from 0 up to 6,
//  the factor reduction takes one step per cycle, and four words leave one
//  per accepted cycle.
//  s_axis_tready is high only while idle. arst_n clears the sequencer.
//
module pll_frequency_to_register_words_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [pllrw_pkg::FREQ_W-1:0] s_axis_tdata,   // [23:0] freq_khz
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [pllrw_pkg::WORD_W-1:0] m_axis_tdata,   // [31:0] reg_word
	output logic                         m_axis_tlast
);
	import pllrw_pkg::*;

	state_t state_q, state_d;

	logic [FCLP_W-1:0] f_q;
	logic [DIVX_W-1:0] div_x_q;
	logic [PROD_W-1:0] prod_q;
	logic              vco_phase_q;
	logic [MHZ_W-1:0]  mhz_q;
	logic [CODE_W-1:0] k_q;
	logic [CODE_W-1:0] code_q;
	logic [QUO_W-1:0]  ival_q;
	logic [REM_W-1:0]  frac_q;
	logic [EXP_W-1:0]  e5_q;
	logic [EXP_W-1:0]  e2_q;
	logic [IDX_W-1:0]  idx_q;

	logic              in_hs, out_hs;
	logic [FCLP_W-1:0] f_clamp;

	// shared /1000 unit, correction stage
	logic [QUO_W-1:0]  q0;
	logic [29:0]       q0_x1000;
	logic [29:0]       r_full;
	logic [10:0]       r0;
	logic              r_over;
	logic [QUO_W-1:0]  quo;
	logic [REM_W-1:0]  rem;

	// divider search
	logic [18:0]       p_mhz;
	logic              hit;

	// factor reduction
	logic [17:0]       prod5;
	logic [7:0]        q5;
	logic [REM_W-1:0]  q5_x5;
	logic              div5;

	assign in_hs  = s_axis_tvalid & s_axis_tready;
	assign out_hs = m_axis_tvalid & m_axis_tready;

	always_comb begin
		f_clamp = s_axis_tdata[FCLP_W-1:0];
		if (s_axis_tdata < {1'b0, FREQ_MIN_KHZ}) begin
			f_clamp = FREQ_MIN_KHZ;
		end else if (s_axis_tdata > {1'b0, FREQ_MAX_KHZ}) begin
			f_clamp = FREQ_MAX_KHZ;
		end
	end

	// estimate is the true quotient or one less; fix with one compare
	assign q0       = prod_q[PROD_W-1:RCP_SH];
	assign q0_x1000 = ({10'd0, q0} << 10) - ({10'd0, q0} << 4) - ({10'd0, q0} << 3);
	assign r_full   = {1'b0, div_x_q} - q0_x1000;
	assign r0       = r_full[10:0];
	assign r_over   = (r0 >= DIV_BASE);
	assign quo      = r_over ? q0 + QUO_W'(1) : q0;
	assign rem      = r_over ? REM_W'(r0 - DIV_BASE) : r0[REM_W-1:0];

	assign p_mhz = {6'd0, mhz_q} << k_q;
	assign hit   = (p_mhz >= VCO_MIN_MHZ) && (p_mhz <= VCO_MAX_MHZ);

	assign prod5 = frac_q * RCP_5;
	assign q5    = prod5[17:10];
	assign q5_x5 = ({2'd0, q5} << 2) + {2'd0, q5};
	assign div5  = (q5_x5 == frac_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_hs) state_d = ST_MUL;
			ST_MUL:    state_d = ST_FIX;
			ST_FIX:    state_d = vco_phase_q ? ST_RED5 : ST_SEARCH;
			ST_SEARCH: if (hit || k_q == DIV_CODE_MAX) state_d = ST_MUL;
			ST_RED5:   if (!(e5_q != '0 && div5)) state_d = ST_RED2;
			ST_RED2:   if (!(e2_q != '0 && !frac_q[0])) state_d = ST_EMIT;
			ST_EMIT:   if (out_hs && idx_q == IDX_R4) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vco_phase_q <= 1'b0;
			k_q         <= '0;
			e5_q        <= '0;
			e2_q        <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_hs) begin
						vco_phase_q <= 1'b0;
						k_q         <= '0;
						e5_q        <= 2'd3;
						e2_q        <= 2'd3;
						idx_q       <= '0;
					end
				end
				ST_SEARCH: begin
					if (hit || k_q == DIV_CODE_MAX) begin
						vco_phase_q <= 1'b1;
					end else begin
						k_q <= k_q + CODE_W'(1);
					end
				end
				ST_RED5: if (e5_q != '0 && div5) e5_q <= e5_q - EXP_W'(1);
				ST_RED2: if (e2_q != '0 && !frac_q[0]) e2_q <= e2_q - EXP_W'(1);
				ST_EMIT: if (out_hs) idx_q <= idx_q + IDX_W'(1);
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_hs) begin
					f_q     <= f_clamp;
					div_x_q <= {6'd0, f_clamp};
				end
			end
			ST_MUL: prod_q <= div_x_q * RCP_1000;
			ST_FIX: begin
				if (vco_phase_q) begin
					ival_q <= quo;
					frac_q <= rem;
				end else begin
					mhz_q <= quo[MHZ_W-1:0];
				end
			end
			ST_SEARCH: begin
				if (hit || k_q == DIV_CODE_MAX) begin
					code_q  <= k_q;
					div_x_q <= {6'd0, f_q} << k_q;
				end
			end
			ST_RED5: if (e5_q != '0 && div5) frac_q <= {2'd0, q5};
			ST_RED2: if (e2_q != '0 && !frac_q[0]) frac_q <= frac_q >> 1;
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = (state_q == ST_EMIT);
		m_axis_tlast  = (idx_q == IDX_R4);
		unique case (idx_q)
			IDX_RF_OFF: m_axis_tdata = WORD_RF_OFF;
			IDX_R1:     m_axis_tdata = WORD_R1_BASE
				+ {19'd0, mod_value(e2_q, e5_q), 3'd0};
			IDX_R0:     m_axis_tdata = {ival_q[16:0], 15'd0} + {19'd0, frac_q, 3'd0};
			default:    m_axis_tdata = WORD_R4_BASE + {9'd0, code_q, 20'd0};
		endcase
	end

	a_ready_valid_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while output words pending");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_hs |=> (state_q == ST_MUL && !vco_phase_q))
		else $error("accepted request did not start the /1000 unit");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hs && m_axis_tlast) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after R4");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (k_q <= DIV_CODE_MAX))
		else $error("divider search ran past the last code");

	a_fix_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> ($past(state_q) == ST_MUL))
		else $error("correction stage without a multiply before it");

endmodule
